/* rtl/a2b_pkg.sv */
// Shared constants and types for the length-prefix to start-code converter.
`default_nettype none

package a2b_pkg;

  // Default width of the byte position counter
  localparam int POSITION_BITS_DEF = 24;

  // Widths of the sample summary fields
  localparam int START_W = 24;
  localparam int LEN_W   = 25;

  // NAL header type field and the types of interest
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [4:0] NAL_SPS       = 5'h07;
  localparam logic [4:0] NAL_IDR       = 5'h05;
  localparam logic [4:0] NAL_SLICE     = 5'h01;

  // Start code bytes emitted in place of the length prefix
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // One result item
  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic               key;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
  } a2b_result_t;

endpackage

`default_nettype wire

/* rtl/a2b_core.sv */
// Prefix parser: length countdown, NAL type detection and sample summary.
`default_nettype none

module a2b_core #(
  parameter int POSITION_BITS = a2b_pkg::POSITION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         data_in,
  input  wire logic               last_in,
  output a2b_pkg::a2b_result_t    result
);

  localparam int PB = POSITION_BITS;
  localparam int SW = (PB > a2b_pkg::START_W) ? PB : a2b_pkg::START_W;
  localparam int LW = (PB + 1 > a2b_pkg::LEN_W) ? PB + 1 : a2b_pkg::LEN_W;

  typedef enum logic [2:0] {
    PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_HEADER, PH_PAYLOAD
  } phase_t;

  // State
  logic [PB-1:0] pos;
  phase_t        phase;
  logic [23:0]   acc;
  logic [31:0]   rem;
  logic          key_seen;
  logic          slice_seen;
  logic [PB-1:0] start;

  // Updated values before the end-of-sample clear
  phase_t        phase_next;
  logic [23:0]   acc_next;
  logic [31:0]   rem_next;
  logic          key_seen_next;
  logic          slice_seen_next;
  logic [PB-1:0] start_next;
  logic [7:0]    data_o;

  logic [4:0]    nal_type;
  logic [PB-1:0] prefix_off;
  logic [PB:0]   count;
  logic [PB:0]   len_full;
  logic [LW-1:0] len_ext;
  logic [SW-1:0] start_ext;

  assign nal_type   = 5'(data_in & a2b_pkg::NAL_TYPE_MASK);
  assign prefix_off = (pos >= PB'(4)) ? pos - PB'(4) : '0;

  // Per-byte decode
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    rem_next        = rem;
    key_seen_next   = key_seen;
    slice_seen_next = slice_seen;
    start_next      = start;
    data_o          = data_in;
    unique case (phase)
      PH_LEN0: begin
        acc_next   = {acc[15:0], data_in};
        phase_next = PH_LEN1;
        data_o     = a2b_pkg::SC_ZERO;
      end
      PH_LEN1: begin
        acc_next   = {acc[15:0], data_in};
        phase_next = PH_LEN2;
        data_o     = a2b_pkg::SC_ZERO;
      end
      PH_LEN2: begin
        acc_next   = {acc[15:0], data_in};
        phase_next = PH_LEN3;
        data_o     = a2b_pkg::SC_ZERO;
      end
      PH_LEN3: begin
        rem_next   = {acc, data_in};
        acc_next   = '0;
        phase_next = PH_HEADER;
        data_o     = a2b_pkg::SC_ONE;
      end
      PH_HEADER: begin
        // first key NAL and first plain slice each pick the start offset
        if ((nal_type == a2b_pkg::NAL_SPS || nal_type == a2b_pkg::NAL_IDR) && !key_seen) begin
          key_seen_next = 1'b1;
          start_next    = prefix_off;
        end
        if (nal_type == a2b_pkg::NAL_SLICE && !slice_seen) begin
          slice_seen_next = 1'b1;
          start_next      = prefix_off;
        end
        if (rem == '0) begin
          // empty NAL: this byte also opens the next prefix
          acc_next   = {16'h0000, data_in};
          phase_next = PH_LEN1;
          data_o     = a2b_pkg::SC_ZERO;
        end else begin
          rem_next   = rem - 32'd1;
          phase_next = (rem == 32'd1) ? PH_LEN0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rem != '0) begin
          rem_next = rem - 32'd1;
        end
        if (rem <= 32'd1) begin
          phase_next = PH_LEN0;
        end
      end
      default: begin
        phase_next = PH_LEN0;
      end
    endcase
  end

  // Sample summary, shown only on the last byte
  assign count     = {1'b0, pos} + (PB + 1)'(1);
  assign len_full  = count - {1'b0, start_next};
  assign len_ext   = LW'(len_full);
  assign start_ext = SW'(start_next);

  always_comb begin
    result.data   = data_o;
    result.last   = last_in;
    result.key    = last_in & key_seen_next;
    result.start  = last_in ? start_ext[a2b_pkg::START_W-1:0] : '0;
    result.length = last_in ? len_ext[a2b_pkg::LEN_W-1:0] : '0;
  end

  // State update, cleared after each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      phase      <= PH_LEN0;
      acc        <= '0;
      rem        <= '0;
      key_seen   <= 1'b0;
      slice_seen <= 1'b0;
      start      <= '0;
    end else if (accept) begin
      if (last_in) begin
        pos        <= '0;
        phase      <= PH_LEN0;
        acc        <= '0;
        rem        <= '0;
        key_seen   <= 1'b0;
        slice_seen <= 1'b0;
        start      <= '0;
      end else begin
        if (pos != '1) begin
          pos <= pos + PB'(1);
        end
        phase      <= phase_next;
        acc        <= acc_next;
        rem        <= rem_next;
        key_seen   <= key_seen_next;
        slice_seen <= slice_seen_next;
        start      <= start_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/avcc_to_annexb_converter.sv */
// Top level of the length-prefix to start-code converter.
// Converts one H.264 sample, one byte per item, from 4-byte length prefixes
// to 00 00 00 01 start codes with one result item per input item; a sample's
// last byte also carries the key-frame flag, the start offset and the length
// from that offset to the sample's end. The result is registered and the
// block sustains one byte per clock while out_ready holds high: all decoding
// sits between the parser state and a single result register, and a new item
// is taken whenever that register is empty or is being emptied in the same
// cycle. Byte positions saturate at 2^POSITION_BITS - 1.
`default_nettype none

module avcc_to_annexb_converter #(
  parameter int POSITION_BITS = a2b_pkg::POSITION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    data_in,
  input  wire logic                          last_in,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [7:0]                    data_out,
  output      logic                          last_out,
  output      logic                          key_frame,
  output      logic [a2b_pkg::START_W-1:0]   out_start,
  output      logic [a2b_pkg::LEN_W-1:0]     out_length
);

  logic                 accept;
  a2b_pkg::a2b_result_t res;
  a2b_pkg::a2b_result_t res_q;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  a2b_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .data_in (data_in),
    .last_in (last_in),
    .result  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign data_out   = res_q.data;
  assign last_out   = res_q.last;
  assign key_frame  = res_q.key;
  assign out_start  = res_q.start;
  assign out_length = res_q.length;

endmodule

`default_nettype wire

/* rtl/a2b_checker.sv */
// Port-level checks for the converter, bound to its top level.
`default_nettype none

module a2b_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [7:0]                  data_out,
  input wire logic                        last_out,
  input wire logic                        key_frame,
  input wire logic [a2b_pkg::START_W-1:0] out_start,
  input wire logic [a2b_pkg::LEN_W-1:0]   out_length
);

  // Set while the next result item opens a new sample
  logic first_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_pending <= last_out;
    end
  end

  // Summary fields are zero away from the last byte
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_out |-> !key_frame && out_start == '0 && out_length == '0)
    else $error("summary fields set on a non-final item");

  // A sample always opens with a start code zero byte
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_pending |-> data_out == a2b_pkg::SC_ZERO)
    else $error("sample does not open with a start code byte");

  // An empty result register never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Nothing is shown the cycle after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present straight after reset");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(last_out))
    else $error("stalled result item changed");

endmodule

bind avcc_to_annexb_converter a2b_checker u_a2b_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .data_out   (data_out),
  .last_out   (last_out),
  .key_frame  (key_frame),
  .out_start  (out_start),
  .out_length (out_length)
);

`default_nettype wire
